@@ design/sha256_block_compress_defines.svh @@
// Assertion macros shared by the SHA-256 block compression design.
`ifndef SHA256_BLOCK_COMPRESS_DEFINES_SVH
`define SHA256_BLOCK_COMPRESS_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define SHA256_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define SHA256_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SHA256_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sha256_pkg.sv @@
// Types, constants and round functions for the SHA-256 block compression.
package sha256_pkg;

    // One input item: a message word and its block flags
    typedef struct packed {
        logic [31:0] message_word;
        logic        new_message;
        logic        final_block;
    } t_in_item;

    // One result item: a digest word with its position
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        last_word;
    } t_out_item;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_LOAD,
        ST_ROUND,
        ST_DRAIN,
        ST_WRITE
    } t_state;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned HASH_WORDS  = 8;
    localparam int unsigned ROUNDS      = 64;

    // Round phase counter: last value, covering all rounds and the pipeline tail
    localparam logic [7:0] ROUND_CNT_LAST = 8'(2 * ROUNDS + 1);
    // Load reads two hash words per cycle; the last count only takes in the last read data
    localparam logic [7:0] LOAD_CNT_LAST  = 8'(HASH_WORDS / 2);
    // Write-back reads one word per cycle; the last count only writes the last sum
    localparam logic [7:0] WRITE_CNT_LAST = 8'(HASH_WORDS);
    localparam logic [3:0] BLOCK_SLOT_LAST = 4'(BLOCK_WORDS - 1);
    localparam logic [2:0] DIGEST_IDX_LAST = 3'(HASH_WORDS - 1);

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Sequencer to datapath controls
    typedef struct packed {
        logic       ld_en;      // load a pair of working variables
        logic [1:0] ld_pair;
        logic [7:0] h_valid;    // hash words written since the last reload
        logic       b_en;       // schedule phase B: first partial sum
        logic       b_expand;
        logic       c_en;       // schedule phase C: word done, pre-add h + K
        logic       c_expand;
        logic [5:0] c_round;
        logic       d_en;       // round update
        logic       wb_en;      // hash write-back
        logic [2:0] wb_idx;
    } t_ctrl;

    // Schedule memory port
    typedef struct packed {
        logic        we;
        logic [3:0]  waddr;
        logic [31:0] wdata;
        logic [3:0]  raddr0;
        logic [3:0]  raddr1;
    } t_sched_port;

    // Hash memory port (write data comes from the datapath)
    typedef struct packed {
        logic       we;
        logic [2:0] waddr;
        logic [2:0] raddr0;
        logic [2:0] raddr1;
    } t_hash_port;

    function automatic logic [31:0] small_s0(input logic [31:0] v);
        return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ (v >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] v);
        return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ (v >> 10);
    endfunction

    function automatic logic [31:0] large_s0(input logic [31:0] v);
        return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
    endfunction

    function automatic logic [31:0] large_s1(input logic [31:0] v);
        return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

@@ design/sha256_ram.sv @@
// Generic RAM: one write port, two registered read ports.
module sha256_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 16,
    localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr0,
    input  logic [AddrW-1:0] i_raddr1,
    output logic [Width-1:0] o_rdata0,
    output logic [Width-1:0] o_rdata1
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata0;
    logic [Width-1:0] r_rdata1;

    // Write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

@@ design/sha256_core.sv @@
// SHA-256 datapath: working variables, schedule expansion, round and hash sums.
module sha256_core (
    input  logic                i_clk,
    input  sha256_pkg::t_ctrl   i_ctrl,
    input  logic [31:0]         i_sched_rd0,
    input  logic [31:0]         i_sched_rd1,
    input  logic [31:0]         i_hash_rd0,
    input  logic [31:0]         i_hash_rd1,
    output logic [31:0]         o_sched_w,
    output logic [31:0]         o_hash_sum
);

    logic [31:0] r_v [8];
    logic [31:0] r_wpart;
    logic [31:0] r_hkw;

    logic [2:0]  w_lo_idx;
    logic [2:0]  w_hi_idx;
    logic [31:0] w_lo_word;
    logic [31:0] w_hi_word;
    logic [31:0] w_old_hash;
    logic [31:0] w_t1;
    logic [31:0] w_t2;

    // Hash words not written since reload read as the initial values
    always_comb begin
        w_lo_idx  = {i_ctrl.ld_pair, 1'b0};
        w_hi_idx  = {i_ctrl.ld_pair, 1'b1};
        w_lo_word = i_ctrl.h_valid[w_lo_idx] ? i_hash_rd0 : sha256_pkg::INIT_HASH[w_lo_idx];
        w_hi_word = i_ctrl.h_valid[w_hi_idx] ? i_hash_rd1 : sha256_pkg::INIT_HASH[w_hi_idx];
        w_old_hash = i_ctrl.h_valid[i_ctrl.wb_idx] ? i_hash_rd0
                                                   : sha256_pkg::INIT_HASH[i_ctrl.wb_idx];
    end

    // Schedule word: plain word for rounds 0..15, expanded after that
    assign o_sched_w = i_ctrl.c_expand
                     ? r_wpart + sha256_pkg::small_s0(i_sched_rd0) + i_sched_rd1
                     : r_wpart;

    // Hash update sum
    assign o_hash_sum = w_old_hash + r_v[i_ctrl.wb_idx];

    // Round terms
    assign w_t1 = r_hkw + sha256_pkg::large_s1(r_v[4]) + sha256_pkg::choose(r_v[4], r_v[5], r_v[6]);
    assign w_t2 = sha256_pkg::large_s0(r_v[0]) + sha256_pkg::majority(r_v[0], r_v[1], r_v[2]);

    // Working variables
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_en) begin
            r_v[w_lo_idx] <= w_lo_word;
            r_v[w_hi_idx] <= w_hi_word;
        end else if (i_ctrl.d_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    // Schedule partial sum and h + K + W pre-add
    always_ff @(posedge i_clk) begin
        if (i_ctrl.b_en) begin
            r_wpart <= i_ctrl.b_expand ? sha256_pkg::small_s1(i_sched_rd0) + i_sched_rd1
                                       : i_sched_rd0;
        end
        if (i_ctrl.c_en) begin
            r_hkw <= r_v[7] + sha256_pkg::ROUND_K[i_ctrl.c_round] + o_sched_w;
        end
    end

endmodule

@@ design/sha256_emit.sv @@
// Digest buffer and output register for the eight digest items.
module sha256_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_dig_we,
    input  logic [2:0]            i_dig_idx,
    input  logic [31:0]           i_dig_data,
    input  logic                  i_ready,
    output logic                  o_valid,
    output sha256_pkg::t_out_item o_item,
    output logic                  o_busy
);

    logic [31:0]           r_dig [8];
    logic                  r_busy;
    logic [2:0]            r_idx;
    logic                  r_out_valid;
    sha256_pkg::t_out_item r_out;
    logic                  w_load;

    assign w_load = r_busy && (!r_out_valid || i_ready);

    // Digest buffer, filled during write-back
    always_ff @(posedge i_clk) begin
        if (i_dig_we) begin
            r_dig[i_dig_idx] <= i_dig_data;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.digest_word  <= r_dig[r_idx];
            r_out.digest_index <= r_idx;
            r_out.last_word    <= (r_idx == sha256_pkg::DIGEST_IDX_LAST);
        end
    end

    // Emit control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_idx       <= r_idx + 3'd1;
                if (r_idx == sha256_pkg::DIGEST_IDX_LAST) begin
                    r_busy <= 1'b0;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            // buffer complete: start readout
            if (i_dig_we && i_dig_idx == sha256_pkg::DIGEST_IDX_LAST) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;
    assign o_busy  = r_busy;

endmodule

@@ design/sha256_ctrl.sv @@
// Sequencer: block collection, hash load, round phases and write-back.
module sha256_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  sha256_pkg::t_in_item    i_item,
    output logic                    o_ready,
    input  logic                    i_emit_busy,
    input  logic [31:0]             i_sched_w,
    output sha256_pkg::t_ctrl       o_ctrl,
    output sha256_pkg::t_sched_port o_sched,
    output sha256_pkg::t_hash_port  o_hash,
    output logic                    o_dig_we
);

    sha256_pkg::t_state r_state, n_state;
    logic [7:0] r_cnt, n_cnt;
    logic [3:0] r_word_cnt, n_word_cnt;
    logic       r_pend, n_pend;
    logic       r_emit, n_emit;
    logic [7:0] r_hvalid, n_hvalid;

    logic       w_acc;
    logic [3:0] w_slot;
    logic       w_pend_acc;
    logic [5:0] w_round_ab;
    logic [5:0] w_round_cd;
    logic       w_exp_ab;
    logic       w_exp_cd;
    logic       w_ph_a;
    logic       w_ph_b;
    logic       w_ph_c;
    logic       w_ph_d;
    logic [2:0] w_cnt_m1;

    // Decode of the counter
    always_comb begin
        w_acc      = i_valid && o_ready;
        w_slot     = i_item.new_message ? 4'd0 : r_word_cnt;
        w_pend_acc = (r_pend && !i_item.new_message) || i_item.final_block;
        w_round_ab = r_cnt[6:1];
        w_round_cd = 6'(r_cnt[7:1] - 7'd1);
        w_exp_ab   = (w_round_ab[5:4] != 2'd0);
        w_exp_cd   = (w_round_cd[5:4] != 2'd0);
        w_ph_a     = (r_state == sha256_pkg::ST_ROUND) && !r_cnt[0] && !r_cnt[7];
        w_ph_b     = (r_state == sha256_pkg::ST_ROUND) && r_cnt[0] && !r_cnt[7];
        w_ph_c     = (r_state == sha256_pkg::ST_ROUND) && !r_cnt[0] && (r_cnt != 8'd0);
        w_ph_d     = (r_state == sha256_pkg::ST_ROUND) && r_cnt[0] && (r_cnt != 8'd1);
        w_cnt_m1   = 3'(r_cnt[2:0] - 3'd1);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha256_pkg::ST_COLLECT: begin
                if (w_acc && w_slot == sha256_pkg::BLOCK_SLOT_LAST) begin
                    n_state = sha256_pkg::ST_LOAD;
                end
            end
            sha256_pkg::ST_LOAD: begin
                if (r_cnt == sha256_pkg::LOAD_CNT_LAST) begin
                    n_state = sha256_pkg::ST_ROUND;
                end
            end
            sha256_pkg::ST_ROUND: begin
                if (r_cnt == sha256_pkg::ROUND_CNT_LAST) begin
                    n_state = (r_emit && i_emit_busy) ? sha256_pkg::ST_DRAIN
                                                      : sha256_pkg::ST_WRITE;
                end
            end
            sha256_pkg::ST_DRAIN: begin
                if (!i_emit_busy) begin
                    n_state = sha256_pkg::ST_WRITE;
                end
            end
            sha256_pkg::ST_WRITE: begin
                if (r_cnt == sha256_pkg::WRITE_CNT_LAST) begin
                    n_state = sha256_pkg::ST_COLLECT;
                end
            end
            default: n_state = sha256_pkg::ST_COLLECT;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready  = (r_state == sha256_pkg::ST_COLLECT);
        o_ctrl   = '0;
        o_sched  = '0;
        o_hash   = '0;
        o_dig_we = 1'b0;

        o_ctrl.h_valid  = r_hvalid;
        o_ctrl.ld_pair  = w_cnt_m1[1:0];
        o_ctrl.c_round  = w_round_cd;
        o_ctrl.wb_idx   = w_cnt_m1;
        o_ctrl.b_en     = w_ph_b;
        o_ctrl.b_expand = w_exp_ab;
        o_ctrl.c_en     = w_ph_c;
        o_ctrl.c_expand = w_exp_cd;
        o_ctrl.d_en     = w_ph_d;

        unique case (r_state)
            sha256_pkg::ST_COLLECT: begin
                o_sched.we    = w_acc;
                o_sched.waddr = w_slot;
                o_sched.wdata = i_item.message_word;
            end
            sha256_pkg::ST_LOAD: begin
                o_ctrl.ld_en  = (r_cnt != 8'd0);
                o_hash.raddr0 = {r_cnt[1:0], 1'b0};
                o_hash.raddr1 = {r_cnt[1:0], 1'b1};
            end
            sha256_pkg::ST_ROUND: begin
                // phase C writes the expanded word back into its slot
                o_sched.we    = w_ph_c && w_exp_cd;
                o_sched.waddr = w_round_cd[3:0];
                o_sched.wdata = i_sched_w;
                if (w_ph_a) begin
                    o_sched.raddr0 = w_exp_ab ? 4'(w_round_ab[3:0] - 4'd2) : w_round_ab[3:0];
                    o_sched.raddr1 = 4'(w_round_ab[3:0] - 4'd7);
                end else begin
                    // phase B: words r-15 and r-16
                    o_sched.raddr0 = 4'(w_round_ab[3:0] + 4'd1);
                    o_sched.raddr1 = w_round_ab[3:0];
                end
            end
            sha256_pkg::ST_DRAIN: begin
                o_hash.raddr0 = '0;
            end
            sha256_pkg::ST_WRITE: begin
                o_ctrl.wb_en  = (r_cnt != 8'd0);
                o_hash.raddr0 = r_cnt[2:0];
                o_hash.we     = (r_cnt != 8'd0);
                o_hash.waddr  = w_cnt_m1;
                o_dig_we      = (r_cnt != 8'd0) && r_emit;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // Counters and block flags
    always_comb begin
        n_word_cnt = r_word_cnt;
        n_pend     = r_pend;
        n_emit     = r_emit;
        n_hvalid   = r_hvalid;

        if (n_state != r_state) begin
            n_cnt = '0;
        end else if (r_state == sha256_pkg::ST_LOAD || r_state == sha256_pkg::ST_ROUND ||
                     r_state == sha256_pkg::ST_WRITE) begin
            n_cnt = r_cnt + 8'd1;
        end else begin
            n_cnt = r_cnt;
        end

        if (w_acc) begin
            if (i_item.new_message) begin
                n_hvalid = '0;
            end
            if (w_slot == sha256_pkg::BLOCK_SLOT_LAST) begin
                n_word_cnt = '0;
                n_emit     = w_pend_acc;
                n_pend     = 1'b0;
            end else begin
                n_word_cnt = w_slot + 4'd1;
                n_pend     = w_pend_acc;
            end
        end

        if (o_ctrl.wb_en) begin
            n_hvalid[w_cnt_m1] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sha256_pkg::ST_COLLECT;
            r_cnt      <= '0;
            r_word_cnt <= '0;
            r_pend     <= 1'b0;
            r_emit     <= 1'b0;
            r_hvalid   <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_word_cnt <= n_word_cnt;
            r_pend     <= n_pend;
            r_emit     <= n_emit;
            r_hvalid   <= n_hvalid;
        end
    end

endmodule

@@ design/sha256_block_compress.sv @@
// Top level of the SHA-256 block compression with digest readout.
// Items are taken one per cycle while a block is collected; the sixteenth starts the busy
// phases: hash load, the 64 rounds (two schedule read ports), write-back, plus a wait while
// an earlier digest is still being read out.
// A final block gives its digest items after its write-back, one per cycle while i_ready is high.
// Reset clears control and hash valid bits (hash reads as initial values); the
// schedule memory is not cleared.
`include "sha256_block_compress_defines.svh"

module sha256_block_compress (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  sha256_pkg::t_in_item  i_item,
    output logic                  o_ready,
    output logic                  o_valid,
    output sha256_pkg::t_out_item o_item,
    input  logic                  i_ready
);

    sha256_pkg::t_ctrl       w_ctrl;
    sha256_pkg::t_sched_port w_sched;
    sha256_pkg::t_hash_port  w_hash;
    logic [31:0] w_sched_rd0;
    logic [31:0] w_sched_rd1;
    logic [31:0] w_hash_rd0;
    logic [31:0] w_hash_rd1;
    logic [31:0] w_sched_w;
    logic [31:0] w_hash_sum;
    logic        w_dig_we;
    logic        w_emit_busy;

    // Sequencer
    sha256_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_item      (i_item),
        .o_ready     (o_ready),
        .i_emit_busy (w_emit_busy),
        .i_sched_w   (w_sched_w),
        .o_ctrl      (w_ctrl),
        .o_sched     (w_sched),
        .o_hash      (w_hash),
        .o_dig_we    (w_dig_we)
    );

    // Message schedule window
    sha256_ram #(
        .Width (32),
        .Depth (16)
    ) u_sched_ram (
        .i_clk    (i_clk),
        .i_we     (w_sched.we),
        .i_waddr  (w_sched.waddr),
        .i_wdata  (w_sched.wdata),
        .i_raddr0 (w_sched.raddr0),
        .i_raddr1 (w_sched.raddr1),
        .o_rdata0 (w_sched_rd0),
        .o_rdata1 (w_sched_rd1)
    );

    // Hash state
    sha256_ram #(
        .Width (32),
        .Depth (8)
    ) u_hash_ram (
        .i_clk    (i_clk),
        .i_we     (w_hash.we),
        .i_waddr  (w_hash.waddr),
        .i_wdata  (w_hash_sum),
        .i_raddr0 (w_hash.raddr0),
        .i_raddr1 (w_hash.raddr1),
        .o_rdata0 (w_hash_rd0),
        .o_rdata1 (w_hash_rd1)
    );

    // Round datapath
    sha256_core u_core (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_sched_rd0 (w_sched_rd0),
        .i_sched_rd1 (w_sched_rd1),
        .i_hash_rd0  (w_hash_rd0),
        .i_hash_rd1  (w_hash_rd1),
        .o_sched_w   (w_sched_w),
        .o_hash_sum  (w_hash_sum)
    );

    // Digest readout
    sha256_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dig_we   (w_dig_we),
        .i_dig_idx  (w_ctrl.wb_idx),
        .i_dig_data (w_hash_sum),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_item     (o_item),
        .o_busy     (w_emit_busy)
    );

    // No item is taken while rounds are in flight
    `SHA256_ASSERT_IMP(a_no_take_in_rounds, o_ready, !(w_ctrl.c_en || w_ctrl.d_en), "item taken during rounds")
    // The digest buffer is never refilled while a readout is still running
    `SHA256_ASSERT_IMP(a_no_dig_overrun, w_dig_we, !w_emit_busy, "digest buffer overwritten")
    // After the last digest item, a new readout starts at word zero
    `SHA256_ASSERT_NXT(a_restart_index, o_valid && i_ready && o_item.last_word, !o_valid || o_item.digest_index == 3'd0, "digest readout out of order")

endmodule

@@ tb/sv/tb_sha256_block_compress.sv @@
// Self-checking testbench for the SHA-256 block compression with digest readout.
module tb_sha256_block_compress;

    localparam int ITEM_TARGET  = 410;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 200;
    localparam int SCRIPT_ROWS  = 20;
    localparam int REPORT_LIMIT = 10;

    // Round constants and initial hash, kept locally for the predictor
    localparam logic [31:0] HASH_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SEED_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Well-known digest of the message "abc"
    localparam logic [31:0] ABC_DIGEST [8] = '{
        32'hba7816bf, 32'h8f01cfea, 32'h414140de, 32'h5dae2223,
        32'hb00361a3, 32'h96177a9c, 32'hb410ff61, 32'hf20015ad
    };

    // Directed rows: word, new_message, final_block, digest typed in above
    typedef struct packed {
        logic [31:0] word;
        logic        start;
        logic        fin;
        logic        known;
    } t_script_row;

    localparam t_script_row SCRIPT [SCRIPT_ROWS] = '{
        // padded "abc" right after reset, no start flag, final on one word only
        '{32'h61626380, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b1, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000018, 1'b0, 1'b0, 1'b1},
        // partial block of extremes marked final, then dropped by a restart
        '{32'hffffffff, 1'b1, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b1, 1'b0},
        '{32'hffffffff, 1'b0, 1'b0, 1'b0},
        '{32'h80000001, 1'b1, 1'b0, 1'b0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  in_valid;
    sha256_pkg::t_in_item  in_item;
    logic                  o_ready;
    logic                  o_valid;
    sha256_pkg::t_out_item o_item;
    logic                  out_ready;
    logic                  row_known;

    // Predictor state
    logic [31:0]           chain_hash [8];
    logic [31:0]           block_words [16];
    int                    words_in_block;
    bit                    digest_armed;
    sha256_pkg::t_out_item pending_digest [$];

    int bad_words;
    int words_sent;
    bit steady_out;

    sha256_block_compress dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_item  (in_item),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_ready (out_ready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] lo_sig0(input logic [31:0] v);
        return ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [31:0] lo_sig1(input logic [31:0] v);
        return ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
    endfunction

    function automatic logic [31:0] up_sig0(input logic [31:0] v);
        return ror(v, 2) ^ ror(v, 13) ^ ror(v, 22);
    endfunction

    function automatic logic [31:0] up_sig1(input logic [31:0] v);
        return ror(v, 6) ^ ror(v, 11) ^ ror(v, 25);
    endfunction

    // 64 rounds over the collected block, then fold into the chaining hash
    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int r = 0; r < 16; r++) w[r] = block_words[r];
        for (int r = 16; r < 64; r++)
            w[r] = lo_sig1(w[r-2]) + w[r-7] + lo_sig0(w[r-15]) + w[r-16];
        for (int j = 0; j < 8; j++) v[j] = chain_hash[j];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + up_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + HASH_K[r] + w[r];
            t2 = up_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) chain_hash[j] = chain_hash[j] + v[j];
    endfunction

    // Take one message word; returns the number of digest words it releases
    function automatic int absorb_word(input sha256_pkg::t_in_item it);
        sha256_pkg::t_out_item d;
        if (it.new_message) begin
            for (int j = 0; j < 8; j++) chain_hash[j] = SEED_HASH[j];
            words_in_block = 0;
            digest_armed = 1'b0;
        end
        if (it.final_block) digest_armed = 1'b1;
        block_words[words_in_block] = it.message_word;
        words_in_block++;
        if (words_in_block < 16) return 0;
        words_in_block = 0;
        compress_block();
        if (!digest_armed) return 0;
        digest_armed = 1'b0;
        for (int j = 0; j < 8; j++) begin
            d.digest_word  = chain_hash[j];
            d.digest_index = 3'(j);
            d.last_word    = (j == 7);
            pending_digest.push_back(d);
        end
        return 8;
    endfunction

    function automatic void flag_mismatch(input sha256_pkg::t_out_item want,
                                          input sha256_pkg::t_out_item got);
        if (bad_words < REPORT_LIMIT)
            $display("digest mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                     want.digest_word, want.digest_index, want.last_word,
                     got.digest_word, got.digest_index, got.last_word);
        bad_words++;
    endfunction

    // Short gaps mostly, a long one now and then
    function automatic int idle_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(12, 40);
    endfunction

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h00000000;
        if (r == 1) return 32'hffffffff;
        return $urandom;
    endfunction

    // Predict on accepted items, check accepted digest words
    always @(posedge i_clk) begin
        int made;
        sha256_pkg::t_out_item want;
        if (i_rst_n) begin
            if (in_valid && o_ready) begin
                made = absorb_word(in_item);
                if (row_known && made == 8)
                    for (int j = 0; j < 8; j++)
                        pending_digest[pending_digest.size() - 8 + j].digest_word = ABC_DIGEST[j];
            end
            if (o_valid && out_ready) begin
                if (pending_digest.size() == 0) begin
                    want = '0;
                    if (bad_words < REPORT_LIMIT) $display("unexpected digest word:");
                    flag_mismatch(want, o_item);
                end else begin
                    want = pending_digest.pop_front();
                    if (want.digest_word !== o_item.digest_word
                        || want.digest_index !== o_item.digest_index
                        || want.last_word !== o_item.last_word)
                        flag_mismatch(want, o_item);
                end
            end
        end
    end

    // Result side back-pressure, with steady stretches
    initial begin
        int hold;
        hold = 0;
        steady_out = 1'b0;
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) steady_out = !steady_out;
            if (hold > 0) begin
                out_ready <= 1'b0;
                hold--;
            end else begin
                out_ready <= 1'b1;
                if (!steady_out && $urandom_range(0, 99) < 30) hold = idle_len();
            end
        end
    end

    // Present one item after an optional gap and hold it until taken
    task automatic push_word(input sha256_pkg::t_in_item it, input int gap, input logic known);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid  <= 1'b1;
        in_item   <= it;
        row_known <= known;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    function automatic int input_gap(input bit steady);
        if (steady || $urandom_range(0, 99) < 50) return 0;
        return idle_len();
    endfunction

    // Stimulus and end of run
    initial begin
        sha256_pkg::t_in_item it;
        int kind;
        int blocks;
        int fin_at;
        int burst;
        int drain;
        bit chain_only;
        bit steady_in;

        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        row_known = 1'b0;
        bad_words = 0;
        words_sent = 0;
        words_in_block = 0;
        digest_armed = 1'b0;
        for (int j = 0; j < 8; j++) chain_hash[j] = SEED_HASH[j];
        for (int j = 0; j < 16; j++) block_words[j] = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows
        for (int i = 0; i < SCRIPT_ROWS; i++) begin
            it.message_word = SCRIPT[i].word;
            it.new_message  = SCRIPT[i].start;
            it.final_block  = SCRIPT[i].fin;
            push_word(it, input_gap(1'b0), SCRIPT[i].known);
        end

        // Random messages, mostly well formed, some noise
        while (words_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            steady_in = ($urandom_range(0, 4) == 0);
            if (kind < 8) begin
                blocks = $urandom_range(1, 3);
                chain_only = ($urandom_range(0, 9) == 0);
                fin_at = $urandom_range(0, 15);
                for (int b = 0; b < blocks; b++) begin
                    for (int w = 0; w < 16; w++) begin
                        it.message_word = pick_word();
                        it.new_message  = (b == 0 && w == 0 && !chain_only);
                        it.final_block  = (b == blocks - 1)
                                          && (w == fin_at || $urandom_range(0, 3) == 0);
                        push_word(it, input_gap(steady_in), 1'b0);
                    end
                end
            end else begin
                burst = $urandom_range(1, 20);
                for (int n = 0; n < burst; n++) begin
                    it.message_word = pick_word();
                    it.new_message  = ($urandom_range(0, 3) == 0);
                    it.final_block  = ($urandom_range(0, 1) == 1);
                    push_word(it, input_gap(steady_in), 1'b0);
                end
            end
        end
        @(negedge i_clk);
        in_valid <= 1'b0;

        drain = 0;
        while (pending_digest.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_digest.size() != 0) begin
            $display("%0d digest words never arrived", pending_digest.size());
            bad_words += pending_digest.size();
        end

        if (bad_words == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule
